// ===== rtl/annexb_nal_unit_splitter_defines.svh =====
// Assertion macros shared by the NAL unit splitter RTL.
// Each macro expects clk and rst_n in scope; no other dependencies.
`ifndef ANNEXB_NAL_UNIT_SPLITTER_DEFINES_SVH
`define ANNEXB_NAL_UNIT_SPLITTER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define ANBS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define ANBS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/anbs_pkg.sv =====
// Package for the Annex B NAL unit splitter: payload structs, queue sizing
// and position width defaults. No dependencies.
package anbs_pkg;

  localparam int POSITION_BITS_DEF = 24;
  localparam int NAL_POS_W         = 24;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] SC_END_BYTE = 8'h01;
  localparam logic [2:0] SC_LEN_3    = 3'd3;
  localparam logic [2:0] SC_LEN_4    = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic                 nal_valid;
    logic [NAL_POS_W-1:0] nal_offset;
    logic [NAL_POS_W-1:0] nal_length;
    logic [2:0]           start_code_length;
    logic [7:0]           nal_header;
    logic                 end_of_buffer;
  } out_t;

  typedef struct packed {
    logic push;
    out_t rec;
  } push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

// ===== rtl/anbs_front.sv =====
// Front end: accepts bytes, tracks start codes and positions, builds records.
// Depends on anbs_pkg and annexb_nal_unit_splitter_defines.svh.
`include "annexb_nal_unit_splitter_defines.svh"

module anbs_front #(
  parameter int POSITION_BITS = anbs_pkg::POSITION_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  anbs_pkg::in_t     in_data,
  input  logic              q_full,
  output logic              in_ready,
  output anbs_pkg::push_t   push
);

  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [POSITION_BITS-1:0] start_r, start_nxt;
  logic [1:0]               zrun_r, zrun_nxt;
  logic                     inside_r, inside_nxt;
  logic [2:0]               sclen_r, sclen_nxt;
  logic [7:0]               hdr_r, hdr_nxt;
  logic                     pend_r, pend_nxt;

  logic                     accept;
  logic [7:0]               d;
  logic                     last;
  logic [7:0]               hdr_cur;
  logic                     is_sc;
  logic                     sc4;
  logic [POSITION_BITS-1:0] back;
  logic [POSITION_BITS-1:0] pos_inc;
  logic [POSITION_BITS-1:0] end_sc;
  logic [POSITION_BITS-1:0] end_pos;
  logic                     have;
  logic                     emit;
  logic [POSITION_BITS-1:0] len;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign d        = in_data.data_byte;
  assign last     = in_data.last_byte;
  assign hdr_cur  = pend_r ? d : hdr_r;
  assign is_sc    = (d == anbs_pkg::SC_END_BYTE) && zrun_r[1];
  assign sc4      = (zrun_r == 2'd3);
  assign back     = {{(POSITION_BITS-2){1'b0}}, (sc4 ? 2'd3 : 2'd2)};
  assign pos_inc  = (&pos_r) ? pos_r : pos_r + 1'b1;
  assign end_sc   = pos_r - back;
  assign end_pos  = is_sc ? end_sc : pos_inc;

  always_comb begin
    if (is_sc) begin
      have = inside_r && (pos_r >= back) && (end_sc > start_r);
      emit = have || last;
    end else begin
      have = inside_r && (pos_inc > start_r);
      emit = last;
    end
  end

  assign len = end_pos - start_r;

  always_comb begin
    push.push                  = accept && emit;
    push.rec.nal_valid         = have;
    push.rec.nal_offset        = have ? anbs_pkg::NAL_POS_W'(start_r) : '0;
    push.rec.nal_length        = have ? anbs_pkg::NAL_POS_W'(len) : '0;
    push.rec.start_code_length = have ? sclen_r : 3'd0;
    push.rec.nal_header        = have ? hdr_cur : 8'd0;
    push.rec.end_of_buffer     = last;
  end

  always_comb begin
    pos_nxt    = pos_r;
    start_nxt  = start_r;
    zrun_nxt   = zrun_r;
    inside_nxt = inside_r;
    sclen_nxt  = sclen_r;
    hdr_nxt    = hdr_r;
    pend_nxt   = pend_r;
    if (accept) begin
      if (last) begin
        pos_nxt    = '0;
        start_nxt  = '0;
        zrun_nxt   = 2'd0;
        inside_nxt = 1'b0;
        sclen_nxt  = 3'd0;
        hdr_nxt    = 8'd0;
        pend_nxt   = 1'b0;
      end else begin
        pos_nxt  = pos_inc;
        zrun_nxt = (d != 8'd0) ? 2'd0 : (sc4 ? 2'd3 : zrun_r + 2'd1);
        if (is_sc) begin
          inside_nxt = 1'b1;
          start_nxt  = pos_inc;
          sclen_nxt  = sc4 ? anbs_pkg::SC_LEN_4 : anbs_pkg::SC_LEN_3;
          hdr_nxt    = 8'd0;
          pend_nxt   = 1'b1;
        end else if (pend_r) begin
          hdr_nxt  = d;
          pend_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      start_r  <= '0;
      zrun_r   <= 2'd0;
      inside_r <= 1'b0;
      sclen_r  <= 3'd0;
      hdr_r    <= 8'd0;
      pend_r   <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      start_r  <= start_nxt;
      zrun_r   <= zrun_nxt;
      inside_r <= inside_nxt;
      sclen_r  <= sclen_nxt;
      hdr_r    <= hdr_nxt;
      pend_r   <= pend_nxt;
    end
  end

  `ANBS_ASSERT_IMP(a_rec_sclen, push.push && push.rec.nal_valid,
    (push.rec.start_code_length == anbs_pkg::SC_LEN_3) ||
    (push.rec.start_code_length == anbs_pkg::SC_LEN_4), "record without start code length")
  `ANBS_ASSERT_NXT(a_last_clears, accept && last,
    (pos_r == '0) && !inside_r && !pend_r && (zrun_r == 2'd0), "state not cleared after last byte")
  `ANBS_ASSERT_IMP(a_pend_no_zeros, pend_r, zrun_r == 2'd0, "header pending after zero byte")

endmodule

// ===== rtl/anbs_queue.sv =====
// Short record queue between front end and output stage.
// Depends on anbs_pkg and annexb_nal_unit_splitter_defines.svh.
`include "annexb_nal_unit_splitter_defines.svh"

module anbs_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  anbs_pkg::push_t    push,
  input  logic               pop,
  output anbs_pkg::qstat_t   stat,
  output anbs_pkg::out_t     head
);

  anbs_pkg::out_t                 mem_r [anbs_pkg::QUEUE_DEPTH];
  logic [anbs_pkg::QUEUE_AW-1:0]  wr_r, wr_nxt;
  logic [anbs_pkg::QUEUE_AW-1:0]  rd_r, rd_nxt;
  logic [anbs_pkg::QUEUE_CW-1:0]  cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == anbs_pkg::QUEUE_CW'(anbs_pkg::QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign head       = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push.push) begin
      wr_nxt = (wr_r == anbs_pkg::QUEUE_AW'(anbs_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (pop) begin
      rd_nxt = (rd_r == anbs_pkg::QUEUE_AW'(anbs_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (push.push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push.push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push.push) begin
      mem_r[wr_r] <= push.rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  `ANBS_ASSERT_IMP(a_no_overflow, push.push, !stat.full || pop, "push into full queue")
  `ANBS_ASSERT_IMP(a_no_underflow, pop, !stat.empty, "pop from empty queue")

endmodule

// ===== rtl/anbs_back.sv =====
// Output stage: pops records from the queue into the result register.
// Depends on anbs_pkg.
module anbs_back (
  input  logic               clk,
  input  logic               rst_n,
  input  anbs_pkg::qstat_t   stat,
  input  anbs_pkg::out_t     head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output anbs_pkg::out_t     out_data
);

  logic           vld_r, vld_nxt;
  anbs_pkg::out_t data_r;

  assign pop       = !stat.empty && (!vld_r || out_ready);
  assign vld_nxt   = pop || (vld_r && !out_ready);
  assign out_valid = vld_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (pop) begin
      data_r <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

endmodule

// ===== rtl/annexb_nal_unit_splitter.sv =====
// Annex B NAL unit splitter, top level.
// Depends on anbs_pkg, anbs_front, anbs_queue and anbs_back.
//
// Usage:
//   in_*  : one stream byte per transfer, last_byte marks the buffer's end.
//   out_* : one record per non-empty NAL unit (offset, length, start code
//           length, header byte), raised on the 01 byte of the next start
//           code; the last byte of a buffer always gives a record with
//           end_of_buffer set, nal_valid low if no NAL unit ends there.
// Throughput: one byte per cycle while in_ready is high; in_ready drops when the queue is full.
// Path: the front end decides in the accepting cycle, the record is
//   written into the two-entry queue, then loads the output register.
// Stall: when out_ready is low the output register holds; the queue
//   takes up to two more records, then in_ready drops until space frees.
// Reset: rst_n (synchronous) clears position, start code tracking, the
//   queue and out_valid; the block is ready for a new buffer right after.
//   Front end state also returns to reset values after each last byte.
module annexb_nal_unit_splitter #(
  parameter int POSITION_BITS = anbs_pkg::POSITION_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  anbs_pkg::in_t    in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output anbs_pkg::out_t   out_data
);

  anbs_pkg::push_t  push;
  anbs_pkg::qstat_t stat;
  anbs_pkg::out_t   head;
  logic             pop;

  anbs_front #(
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .q_full   (stat.full),
    .in_ready (in_ready),
    .push     (push)
  );

  anbs_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .stat  (stat),
    .head  (head)
  );

  anbs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .stat      (stat),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== sim/annexb_nal_unit_splitter_test.sv =====
// Testbench for annexb_nal_unit_splitter: drives Annex B byte buffers and checks
// each NAL unit record against a cycle-free model of the start code parser.
// Depends on anbs_pkg and the annexb_nal_unit_splitter RTL.
`timescale 1ns / 1ps

module annexb_nal_unit_splitter_test;
  import anbs_pkg::*;

  localparam int unsigned ITEM_TARGET = 1650;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned LONG_HOLD = 400;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam longint unsigned POS_MAX = (64'd1 << POSITION_BITS_DEF) - 1;

  // Three buffers: junk, 4-byte code, 3-byte code, empty unit, extra zero,
  // unfinished code at the end; a lone zero; a code ending on the last byte.
  localparam logic [7:0] LEAD_SEQ [26] = '{
    8'hAA, 8'h00, 8'h00, 8'h00, 8'h01, 8'h65, 8'hFF, 8'h00, 8'h00, 8'h01,
    8'h00, 8'h00, 8'h01, 8'h41, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h09,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01
  };

  class nal_record_tracker;
    longint unsigned position;
    longint unsigned nal_start;
    logic [1:0] zero_run;
    bit in_nal;
    bit header_pending;
    logic [2:0] code_len;
    logic [7:0] header;
    out_t pending_records[$];
    int unsigned mismatch_count;

    function new();
      mismatch_count = 0;
      clear();
    endfunction

    function void clear();
      position = 0;
      nal_start = 0;
      zero_run = '0;
      in_nal = 1'b0;
      header_pending = 1'b0;
      code_len = '0;
      header = '0;
    endfunction

    function longint unsigned sat_inc(longint unsigned v);
      return (v >= POS_MAX) ? POS_MAX : v + 1;
    endfunction

    function out_t make_record(bit have, longint unsigned span, bit eob);
      out_t r;
      r = '0;
      if (have) begin
        r.nal_valid = 1'b1;
        r.nal_offset = nal_start[NAL_POS_W-1:0];
        r.nal_length = span[NAL_POS_W-1:0];
        r.start_code_length = code_len;
        r.nal_header = header;
      end
      r.end_of_buffer = eob;
      return r;
    endfunction

    function void take_byte(in_t b);
      longint unsigned pos;
      longint unsigned stop_pos;
      longint unsigned span;
      logic [2:0] sc_len;
      bit have;
      pos = position;
      have = 1'b0;
      span = 0;
      if (header_pending) begin
        header = b.data_byte;
        header_pending = 1'b0;
      end
      if (b.data_byte == SC_END_BYTE && zero_run >= 2'd2) begin
        sc_len = (zero_run == 2'd3) ? SC_LEN_4 : SC_LEN_3;
        if (in_nal && pos >= longint'(sc_len) - 1) begin
          stop_pos = pos - (longint'(sc_len) - 1);
          if (stop_pos > nal_start) begin
            have = 1'b1;
            span = stop_pos - nal_start;
          end
        end
        // close the previous unit before its fields are replaced
        if (have || b.last_byte)
          pending_records.insert(pending_records.size(), make_record(have, span, b.last_byte));
        in_nal = 1'b1;
        nal_start = sat_inc(pos);
        code_len = sc_len;
        header = '0;
        header_pending = 1'b1;
      end else if (b.last_byte) begin
        if (in_nal) begin
          stop_pos = sat_inc(pos);
          if (stop_pos > nal_start) begin
            have = 1'b1;
            span = stop_pos - nal_start;
          end
        end
        pending_records.insert(pending_records.size(), make_record(have, span, 1'b1));
      end
      if (b.data_byte != 8'h00)
        zero_run = 2'd0;
      else if (zero_run != 2'd3)
        zero_run = zero_run + 2'd1;
      position = sat_inc(pos);
      if (b.last_byte)
        clear();
    endfunction

    function void compare_field(string label, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        mismatch_count++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
      end
    endfunction

    function void match_record(out_t got);
      out_t want;
      if (pending_records.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected record, expected none, actual %h", $time, got);
      end else begin
        want = pending_records.pop_front();
        compare_field("nal_valid", want.nal_valid, got.nal_valid);
        compare_field("nal_offset", want.nal_offset, got.nal_offset);
        compare_field("nal_length", want.nal_length, got.nal_length);
        compare_field("start_code_length", want.start_code_length, got.start_code_length);
        compare_field("nal_header", want.nal_header, got.nal_header);
        compare_field("end_of_buffer", want.end_of_buffer, got.end_of_buffer);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  nal_record_tracker nal_track = new();
  in_t byte_stream[$];

  annexb_nal_unit_splitter dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void append_byte(logic [7:0] d, logic l);
    in_t item;
    item.data_byte = d;
    item.last_byte = l;
    byte_stream.insert(byte_stream.size(), item);
  endfunction

  task automatic send_byte(input in_t item, input int unsigned gap);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    nal_track.take_byte(item);
    @(negedge clk);
  endtask

  task automatic accept_record(input int unsigned stall);
    if (stall != 0) begin
      out_ready <= 1'b0;
      repeat (stall) @(negedge clk);
    end
    out_ready <= 1'b1;
    do @(posedge clk); while (!out_valid);
    nal_track.match_record(out_data);
    @(negedge clk);
  endtask

  initial begin : byte_source
    int unsigned nal_cnt;
    int unsigned zeros;
    int unsigned plen;
    int unsigned gap;
    int unsigned pause_at;
    pause_at = 0;
    for (int i = 0; i < 26; i++)
      append_byte(LEAD_SEQ[i], i == 21 || i == 22 || i == 25);
    while (byte_stream.size() < ITEM_TARGET) begin
      if (pause_at == 0 && byte_stream.size() >= ITEM_TARGET / 2)
        pause_at = byte_stream.size();
      if ($urandom_range(0, 4) != 0) begin
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 3)) append_byte(8'($urandom), 1'b0);
        nal_cnt = $urandom_range(1, 6);
        repeat (nal_cnt) begin
          zeros = ($urandom_range(0, 1) == 0) ? 2 : 3;
          if ($urandom_range(0, 5) == 0)
            zeros += $urandom_range(1, 2);
          repeat (zeros) append_byte(8'h00, 1'b0);
          append_byte(SC_END_BYTE, 1'b0);
          plen = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 12);
          repeat (plen)
            append_byte(($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom), 1'b0);
        end
        if ($urandom_range(0, 4) == 0)
          repeat ($urandom_range(1, 3)) append_byte(8'h00, 1'b0);
      end else begin
        repeat ($urandom_range(1, 16)) begin
          case ($urandom_range(0, 4))
            0, 1: append_byte(8'h00, 1'b0);
            2: append_byte(SC_END_BYTE, 1'b0);
            default: append_byte(8'($urandom), 1'b0);
          endcase
        end
      end
      byte_stream[byte_stream.size() - 1].last_byte = 1'b1;
    end

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < byte_stream.size(); i++) begin
      if (i == pause_at) begin
        in_valid <= 1'b0;
        do @(negedge clk); while (nal_track.pending_records.size() != 0);
      end
      gap = ((i / 128) % 3 == 2) ? 0 : $urandom_range(0, 6);
      send_byte(byte_stream[i], gap);
    end
    in_valid <= 1'b0;
    do @(negedge clk); while (nal_track.pending_records.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (nal_track.mismatch_count == 0)
      $display("annexb_nal_unit_splitter regression: pass");
    else
      $display("annexb_nal_unit_splitter regression: fail");
    $finish;
  end

  initial begin : record_sink
    int unsigned seen;
    int unsigned stall;
    bit held;
    seen = 0;
    held = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (!held && seen == 30) begin
        held = 1'b1;
        stall = LONG_HOLD;
      end else begin
        stall = ((seen / 25) % 3 == 1) ? 0 : $urandom_range(0, 6);
      end
      accept_record(stall);
      seen++;
    end
  end

  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("annexb_nal_unit_splitter regression: fail");
    $finish;
  end

endmodule
